FILE: sv/hhpf_pkg.sv
// ============================================================================
// hhpf_pkg
// Shared types, constants and helpers of the hex header packet framer.
// ============================================================================
package hhpf_pkg;

    localparam int unsigned LEN_W      = 12;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QAW        = $clog2(QDEPTH);
    localparam int unsigned QCW        = $clog2(QDEPTH + 1);

    localparam logic [LEN_W-1:0] PAYLOAD_LEN_RESET = 12'd502;

    // Header field selector and character positions inside one field
    localparam logic [1:0] FIELD_CHAN    = 2'd0;
    localparam logic [1:0] FIELD_FILE    = 2'd1;
    localparam logic [1:0] FIELD_PKT     = 2'd2;
    localparam logic [1:0] FIELD_PAYLOAD = 2'd3;

    localparam logic [3:0] POS_PREFIX0 = 4'd0;
    localparam logic [3:0] POS_PREFIX1 = 4'd1;
    localparam logic [3:0] POS_LAST    = 4'd9;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X    = 8'h78;

    localparam logic REQ_PAYLOAD   = 1'b0;
    localparam logic REQ_CNT_RESET = 1'b1;

    // One classified payload item, passed from front to back
    typedef struct packed {
        logic        hdr;
        logic [31:0] chan;
        logic [31:0] file;
        logic [31:0] frame_num;
        logic [7:0]  data;
        logic        frame_end;
    } hhpf_entry_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

FILE: sv/hhpf_queue.sv
// ============================================================================
// hhpf_queue
// Short FIFO of classified items between the front and the back.
// ============================================================================
module hhpf_queue
    import hhpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr,
    input  hhpf_entry_t wr_entry,
    input  logic        rd,
    output hhpf_entry_t head,
    output logic        q_full,
    output logic        q_empty
);

    hhpf_entry_t           mem_reg [QDEPTH];
    logic [QAW-1:0]        wr_ptr_reg;
    logic [QAW-1:0]        wr_ptr_next;
    logic [QAW-1:0]        rd_ptr_reg;
    logic [QAW-1:0]        rd_ptr_next;
    logic [QCW-1:0]        count_reg;
    logic [QCW-1:0]        count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign q_full  = (count_reg == QCW'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (!do_wr && do_rd) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

FILE: sv/hhpf_front.sv
// ============================================================================
// hhpf_front
// Intake: accept items, track frame position and counter, classify items.
// ============================================================================
module hhpf_front
    import hhpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             q_full,
    input  logic             req_type,
    input  logic [7:0]       data_byte,
    input  logic [31:0]      channel_id,
    input  logic [31:0]      file_id,
    input  logic [LEN_W-1:0] payload_len,
    output logic             q_wr,
    output hhpf_entry_t      q_entry
);

    logic [31:0]      packet_counter_reg;
    logic [31:0]      packet_counter_next;
    logic [LEN_W-1:0] slot_index_reg;
    logic [LEN_W-1:0] slot_index_next;
    logic             zero_seen_reg;
    logic             zero_seen_next;
    logic [31:0]      frame_number_reg;
    logic [31:0]      frame_number_next;
    logic             accept;
    logic             start;
    logic             zs;
    logic [LEN_W-1:0] len;
    logic [LEN_W:0]   slot_plus;
    logic             fend;
    logic [31:0]      fn;

    assign accept = push && !q_full;
    assign start  = (slot_index_reg == '0);
    assign fn     = start ? packet_counter_reg : frame_number_reg;
    assign zs     = (!start && zero_seen_reg) || (data_byte == 8'd0);
    assign len    = (payload_len == '0) ? LEN_W'(1) : payload_len;
    assign slot_plus = {1'b0, slot_index_reg} + (LEN_W+1)'(1);
    assign fend   = (slot_plus >= {1'b0, len});

    assign q_wr              = accept && (req_type == REQ_PAYLOAD);
    assign q_entry.hdr       = start;
    assign q_entry.chan      = channel_id;
    assign q_entry.file      = file_id;
    assign q_entry.frame_num = fn;
    assign q_entry.data      = zs ? 8'd0 : data_byte;
    assign q_entry.frame_end = fend;

    always_comb
    begin
        packet_counter_next = packet_counter_reg;
        slot_index_next     = slot_index_reg;
        zero_seen_next      = zero_seen_reg;
        frame_number_next   = frame_number_reg;
        if (accept) begin
            if (req_type == REQ_CNT_RESET) begin
                packet_counter_next = '0;
            end else begin
                frame_number_next = fn;
                if (fend) begin
                    slot_index_next     = '0;
                    zero_seen_next      = 1'b0;
                    packet_counter_next = packet_counter_reg + 32'd1;
                end else begin
                    slot_index_next = slot_plus[LEN_W-1:0];
                    zero_seen_next  = zs;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            packet_counter_reg <= '0;
            slot_index_reg     <= '0;
            zero_seen_reg      <= 1'b0;
            frame_number_reg   <= '0;
        end else begin
            packet_counter_reg <= packet_counter_next;
            slot_index_reg     <= slot_index_next;
            zero_seen_reg      <= zero_seen_next;
            frame_number_reg   <= frame_number_next;
        end
    end

endmodule

FILE: sv/hhpf_back.sv
// ============================================================================
// hhpf_back
// Serializer: expand queued items into header characters and payload bytes.
// ============================================================================
module hhpf_back
    import hhpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hhpf_entry_t head,
    input  logic        q_empty,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        frame_last,
    output logic [31:0] packet_number
);

    logic [1:0]  field_reg;
    logic [1:0]  field_next;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic        run_last_reg;
    logic        frame_last_reg;
    logic [31:0] pnum_reg;
    logic        is_payload;
    logic        load;
    logic [31:0] value;
    logic [3:0]  digit_full;
    logic [2:0]  digit;
    logic [3:0]  nib;
    logic [7:0]  gen_byte;

    assign is_payload = !head.hdr || (field_reg == FIELD_PAYLOAD);
    assign load       = !q_empty && (!out_valid_reg || pop);
    assign q_rd       = load && is_payload;
    assign digit_full = POS_LAST - pos_reg;
    assign digit      = digit_full[2:0];
    assign nib        = value[{digit, 2'b00} +: 4];

    always_comb
    begin
        case (field_reg)
            FIELD_CHAN: value = head.chan;
            FIELD_FILE: value = head.file;
            FIELD_PKT:  value = head.frame_num;
            default:    value = head.frame_num;
        endcase
    end

    always_comb
    begin
        if (is_payload) begin
            gen_byte = head.data;
        end else if (pos_reg == POS_PREFIX0) begin
            gen_byte = CHAR_ZERO;
        end else if (pos_reg == POS_PREFIX1) begin
            gen_byte = CHAR_X;
        end else begin
            gen_byte = hex_char(nib);
        end
    end

    always_comb
    begin
        field_next     = field_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            out_valid_next = 1'b1;
            if (is_payload) begin
                field_next = FIELD_CHAN;
                pos_next   = POS_PREFIX0;
            end else if (pos_reg == POS_LAST) begin
                field_next = field_reg + 2'd1;
                pos_next   = POS_PREFIX0;
            end else begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            field_reg     <= FIELD_CHAN;
            pos_reg       <= POS_PREFIX0;
            out_valid_reg <= 1'b0;
        end else begin
            field_reg     <= field_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg       <= gen_byte;
            run_last_reg   <= is_payload;
            frame_last_reg <= is_payload && head.frame_end;
            pnum_reg       <= head.frame_num;
        end
    end

    assign empty         = !out_valid_reg;
    assign out_byte      = byte_reg;
    assign run_last      = run_last_reg;
    assign frame_last    = frame_last_reg;
    assign packet_number = pnum_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("header character position out of range");

    a_frame_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_last_reg) |-> run_last_reg)
        else $error("frame end marked on a header character");

    a_rd_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |=> (field_reg == FIELD_CHAN && pos_reg == POS_PREFIX0))
        else $error("serializer did not restart after an item");

    a_rd_loads: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |=> out_valid_reg)
        else $error("item dropped from the queue without a result");

endmodule

FILE: sv/hex_header_packet_framer_core.sv
// ============================================================================
// hex_header_packet_framer_core
// Frames payload bytes into fixed-length packets with a 30-byte hex header.
// ============================================================================
// Each frame is a 30-character ASCII header ("0x" plus eight lower-case hex
// digits for channel id, file id and the wrapping packet counter) followed
// by payload_len slots; once a zero byte enters a frame that slot and all
// later ones read as zero, and the last byte carries frame_last. A payload
// item with req_type 0 yields one result, or 31 results when it opens a
// frame; req_type 1 clears the counter and yields nothing. The output
// register is loaded at most once per cycle by the serializer, so while pop
// is held high and items are queued results leave at one per cycle, and
// items enter at one per cycle while the queue has room; the item that opens
// a frame occupies the result port for its whole header before its payload
// byte, and intake stalls once the 4-entry item queue behind that header
// burst fills. An accepted item is written into the item queue and then
// loaded from its head into the output register. payload_len is taken on
// cfg_valid (cfg_ready is always high) and must be written while idle.
// ============================================================================
module hex_header_packet_framer_core
    import hhpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // item intake
    input  logic             push,
    output logic             full,
    input  logic             req_type,
    input  logic [7:0]       data_byte,
    input  logic [31:0]      channel_id,
    input  logic [31:0]      file_id,
    // result output
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             frame_last,
    output logic [31:0]      packet_number,
    // configuration
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data
);

    logic [LEN_W-1:0] payload_len_reg;
    logic [LEN_W-1:0] payload_len_next;
    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;
    hhpf_entry_t      q_entry;
    hhpf_entry_t      q_head;

    // Configuration is always accepted
    assign cfg_ready        = 1'b1;
    assign payload_len_next = (cfg_valid && cfg_ready) ? cfg_data : payload_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_len_reg <= PAYLOAD_LEN_RESET;
        end
        else
        begin
            payload_len_reg <= payload_len_next;
        end
    end

    // Hold intake whenever the item queue is full
    assign full = q_full;

    // Front: classify items and advance frame state
    hhpf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .q_full      (q_full),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .channel_id  (channel_id),
        .file_id     (file_id),
        .payload_len (payload_len_reg),
        .q_wr        (q_wr),
        .q_entry     (q_entry)
    );

    // Queue: decouple intake from serialization
    hhpf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_entry (q_entry),
        .rd       (q_rd),
        .head     (q_head),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    // Back: expand each item into its payload byte, after header characters when it opens a frame
    hhpf_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_empty       (q_empty),
        .q_rd          (q_rd),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .frame_last    (frame_last),
        .packet_number (packet_number)
    );

endmodule
